// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int RAD_W     = 19;                  // radicand, signed
    localparam int SQ_IN_W   = RAD_W - 1 + FRAC_BITS - 2;
    localparam int SQ_RES_W  = (SQ_IN_W + 1) / 2 + 1;
    localparam int SQ_STEPS  = (SQ_IN_W + 1) / 2;
    localparam int NUM_W     = 17;                  // sum or difference of two elements
    localparam int MAG_W     = NUM_W - 1;
    localparam int DIV_NUM_W = MAG_W + FRAC_BITS + 1;
    localparam int DEN_W     = SQ_RES_W + 3;        // 4*big, with room for the +1 rounding
    localparam int Q_W       = DIV_NUM_W;

    localparam logic [1:0] BR_TRACE = 2'd0;
    localparam logic [1:0] BR_X     = 2'd1;
    localparam logic [1:0] BR_Y     = 2'd2;
    localparam logic [1:0] BR_Z     = 2'd3;

    typedef struct packed {
        logic [1:0]                 br;
        logic                       degen;
        logic signed [NUM_W-1:0]    n0;
        logic signed [NUM_W-1:0]    n1;
        logic signed [NUM_W-1:0]    n2;
    } side_t;

endpackage

// ===== design/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Branch choice, radicand and numerator formation, registered.
// ----------------------------------------------------------------------------
module rmq_front
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vin,
    input  logic signed [15:0]       m [9],
    output logic                     vout,
    output logic [SQ_IN_W-1:0]       sq_in,
    output side_t                    side
);

    logic signed [RAD_W-1:0] tr, rad, one;
    logic signed [RAD_W-1:0] e [9];
    side_t                   s_next, side_reg;
    logic [SQ_IN_W-1:0]      sq_next, sq_reg;
    logic                    v_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            e[i] = RAD_W'(m[i]);
        one = RAD_W'(1) <<< FRAC_BITS;
        tr  = e[0] + e[4] + e[8];
        if (tr > 0)
        begin
            s_next.br = BR_TRACE;
            rad = tr + one;
            s_next.n0 = NUM_W'(e[7] - e[5]);
            s_next.n1 = NUM_W'(e[2] - e[6]);
            s_next.n2 = NUM_W'(e[3] - e[1]);
        end
        else if (e[0] > e[4] && e[0] > e[8])
        begin
            s_next.br = BR_X;
            rad = one + e[0] - e[4] - e[8];
            s_next.n0 = NUM_W'(e[7] - e[5]);
            s_next.n1 = NUM_W'(e[1] + e[3]);
            s_next.n2 = NUM_W'(e[2] + e[6]);
        end
        else if (e[4] > e[8])
        begin
            s_next.br = BR_Y;
            rad = one + e[4] - e[0] - e[8];
            s_next.n0 = NUM_W'(e[2] - e[6]);
            s_next.n1 = NUM_W'(e[1] + e[3]);
            s_next.n2 = NUM_W'(e[5] + e[7]);
        end
        else
        begin
            s_next.br = BR_Z;
            rad = one + e[8] - e[0] - e[4];
            s_next.n0 = NUM_W'(e[3] - e[1]);
            s_next.n1 = NUM_W'(e[2] + e[6]);
            s_next.n2 = NUM_W'(e[5] + e[7]);
        end
        s_next.degen = !(rad > 0);
        sq_next = s_next.degen ? '0
                  : SQ_IN_W'({rad[RAD_W-2:0], {(FRAC_BITS-2){1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= s_next;
            sq_reg   <= sq_next;
        end
    end

    assign vout  = v_reg;
    assign sq_in = sq_reg;
    assign side  = side_reg;

endmodule

// ===== design/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined rounded integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vin,
    input  logic [SQ_IN_W-1:0]       x,
    input  side_t                    side_in,
    output logic                     vout,
    output logic [SQ_RES_W-1:0]      big,
    output side_t                    side_out
);

    localparam int RW = SQ_IN_W + 2;

    logic [RW-1:0]       rem_reg  [SQ_STEPS+1];
    logic [RW-1:0]       res_reg  [SQ_STEPS+1];
    side_t               sd_reg   [SQ_STEPS+1];
    logic                v_reg    [SQ_STEPS+1];
    logic [RW-1:0]       rem_next [SQ_STEPS];
    logic [RW-1:0]       res_next [SQ_STEPS];
    logic [SQ_RES_W-1:0] big_reg;
    side_t               sdo_reg;
    logic                vo_reg;

    always_comb
    begin
        rem_reg[0] = RW'(x);
        res_reg[0] = '0;
        sd_reg[0]  = side_in;
        v_reg[0]   = vin;
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - k));
        always_comb
        begin
            if (rem_reg[k] >= res_reg[k] + BIT)
            begin
                rem_next[k] = rem_reg[k] - (res_reg[k] + BIT);
                res_next[k] = (res_reg[k] >> 1) + BIT;
            end
            else
            begin
                rem_next[k] = rem_reg[k];
                res_next[k] = res_reg[k] >> 1;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= rem_next[k];
                res_reg[k+1] <= res_next[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            big_reg <= SQ_RES_W'(res_reg[SQ_STEPS])
                       + SQ_RES_W'(rem_reg[SQ_STEPS] > res_reg[SQ_STEPS]);
            sdo_reg <= sd_reg[SQ_STEPS];
        end
    end

    assign vout     = vo_reg;
    assign big      = big_reg;
    assign side_out = sdo_reg;

endmodule

// ===== design/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider: rounded (mag << FRAC_BITS) / den, capped at one, signed.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vin,
    input  logic signed [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]         den,
    output logic                     vout,
    output logic signed [15:0]       q
);

    localparam int NW = DIV_NUM_W + DEN_W;

    logic [NW-1:0]     n_reg  [DIV_NUM_W+1];
    logic [DEN_W-1:0]  d_reg  [DIV_NUM_W+1];
    logic [DIV_NUM_W-1:0] q_reg [DIV_NUM_W+1];
    logic              s_reg  [DIV_NUM_W+1];
    logic              v_reg  [DIV_NUM_W+1];
    logic [NW-1:0]     n_next [DIV_NUM_W];
    logic [DIV_NUM_W-1:0] q_next [DIV_NUM_W];
    logic [MAG_W:0]    mag;
    logic signed [15:0] qo_reg;
    logic              vo_reg;
    logic signed [DIV_NUM_W+1:0] qs, one;

    always_comb
    begin
        mag = num[NUM_W-1] ? (MAG_W+1)'(-num) : (MAG_W+1)'(num);
        n_reg[0] = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(den >> 1);
        d_reg[0] = den;
        q_reg[0] = '0;
        s_reg[0] = num[NUM_W-1];
        v_reg[0] = vin;
    end

    for (genvar k = 0; k < DIV_NUM_W; k++)
    begin : g_step
        localparam int SH = DIV_NUM_W - 1 - k;
        always_comb
        begin
            n_next[k] = n_reg[k];
            q_next[k] = q_reg[k];
            if ((n_reg[k] >> SH) >= NW'(d_reg[k]))
            begin
                n_next[k] = n_reg[k] - (NW'(d_reg[k]) << SH);
                q_next[k][SH] = 1'b1;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (en)
                v_reg[k+1] <= v_reg[k];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1] <= n_next[k];
                q_reg[k+1] <= q_next[k];
                d_reg[k+1] <= d_reg[k];
                s_reg[k+1] <= s_reg[k];
            end
        end
    end

    always_comb
    begin
        one = (DIV_NUM_W+2)'(1) <<< FRAC_BITS;
        qs  = (DIV_NUM_W+2)'(q_reg[DIV_NUM_W]);
        if (qs > one)
            qs = one;
        if (s_reg[DIV_NUM_W])
            qs = -qs;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (en)
            vo_reg <= v_reg[DIV_NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            qo_reg <= qs[15:0];
    end

    assign vout = vo_reg;
    assign q    = qo_reg;

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.14 rotation matrix to a unit quaternion.
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser
// s_axis   in   m00..m22, 16 bits each, 144 bits    -
// m_axis   out  q_w,q_x,q_y,q_z, 64 bits            branch_taken[1:0], degenerate[2]
//
// One item per cycle unless m_axis stalls; path: front register, 15 square root
// stages, root register, 31 divider stages, quotient register, output register.
// Reset clears all valid bits. A stall on m_axis freezes the whole pipeline
// when the output register is full; the output register lets the pipeline
// drain into it when empty.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,   // q_w,q_x,q_y,q_z
    output logic [7:0]    m_axis_tuser    // branch_taken[1:0],degenerate,zero pad
);

    logic signed [15:0]  m [9];
    logic                en, v1, v2, vd0, vd1, vd2;
    logic [SQ_IN_W-1:0]  sq_in;
    side_t               s1, s2, sd_reg [DIV_NUM_W+2];
    logic [SQ_RES_W-1:0] big;
    logic [DEN_W-1:0]    den;
    logic signed [15:0]  d0, d1, d2, bq;
    logic [SQ_RES_W-1:0] bg_reg [DIV_NUM_W+2];
    logic                ov_reg;
    logic [63:0]         od_reg, od_next;
    logic [7:0]          ou_reg, ou_next;
    logic signed [15:0]  qv [4];

    for (genvar i = 0; i < 9; i++)
    begin : g_in
        assign m[i] = s_axis_tdata[16*i +: 16];
    end

    assign en            = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    rmq_front u_front (.clk, .rst_n, .en, .vin(s_axis_tvalid && en), .m,
                       .vout(v1), .sq_in, .side(s1));

    rmq_sqrt u_sqrt (.clk, .rst_n, .en, .vin(v1), .x(sq_in), .side_in(s1),
                     .vout(v2), .big, .side_out(s2));

    assign den = s2.degen ? DEN_W'(1) : DEN_W'({big, 2'b00});

    rmq_div u_d0 (.clk, .rst_n, .en, .vin(v2), .num(s2.n0), .den, .vout(vd0), .q(d0));
    rmq_div u_d1 (.clk, .rst_n, .en, .vin(v2), .num(s2.n1), .den, .vout(vd1), .q(d1));
    rmq_div u_d2 (.clk, .rst_n, .en, .vin(v2), .num(s2.n2), .den, .vout(vd2), .q(d2));

    always_comb
    begin
        sd_reg[0] = s2;
        bg_reg[0] = big;
    end

    for (genvar k = 0; k < DIV_NUM_W + 1; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_reg[k+1] <= sd_reg[k];
                bg_reg[k+1] <= bg_reg[k];
            end
        end
    end

    always_comb
    begin
        side_t s;
        logic [SQ_RES_W-1:0] b;
        s  = sd_reg[DIV_NUM_W+1];
        b  = bg_reg[DIV_NUM_W+1];
        bq = (b > SQ_RES_W'(1 << FRAC_BITS)) ? 16'(1 << FRAC_BITS) : 16'(b);
        case (s.br)
            BR_TRACE: begin qv[0] = bq; qv[1] = d0; qv[2] = d1; qv[3] = d2; end
            BR_X:     begin qv[0] = d0; qv[1] = bq; qv[2] = d1; qv[3] = d2; end
            BR_Y:     begin qv[0] = d0; qv[1] = d1; qv[2] = bq; qv[3] = d2; end
            default:  begin qv[0] = d0; qv[1] = d1; qv[2] = d2; qv[3] = bq; end
        endcase
        if (s.degen)
            for (int i = 0; i < 4; i++)
                qv[i] = '0;
        od_next = {qv[3], qv[2], qv[1], qv[0]};
        ou_next = {5'b0, s.degen, s.br};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= vd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= od_next;
            ou_reg <= ou_next;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;

    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (vd0 == vd1) && (vd0 == vd2))
        else $error("divider lanes out of step");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == 64'd0)
        else $error("degenerate item not zero");

endmodule
